FILE: src/pwms_pkg.sv
package pwms_pkg;

	localparam int MAX_WIDTH_DEF   = 32;
	localparam int MAX_SEQ_LEN_DEF = 65536;

	localparam int WEIGHT_W  = 16;
	localparam int SUM_W     = 24;
	localparam int POS_W     = 16;
	localparam int HITS_W    = 16;
	localparam int MWIDTH_W  = 6;
	localparam int BASE_W    = 2;
	localparam int WPOS_W    = 5;
	localparam int CFG_IDX_W = 1;
	localparam int S_DATA_W  = 32;
	localparam int M_DATA_W  = 64;

	localparam logic [MWIDTH_W-1:0] MWIDTH_RST = 6'd8;
	localparam logic [POS_W-1:0]    POS_MAX    = '1;
	localparam logic [HITS_W-1:0]   HITS_MAX   = '1;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_BASE = 1'b1;

	localparam logic KIND_WINDOW  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MOTIF_WIDTH   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD = 1'd1;

	typedef logic signed [WEIGHT_W-1:0] weight_t;
	typedef logic signed [SUM_W-1:0]    sum_t;

	localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// one scored window on its way from the cell chain to the scorer
	typedef struct packed {
		logic             go;
		logic             last;
		logic             win;
		logic             bad;
		logic [POS_W-1:0] position;
		sum_t             sum;
	} eval_t;

	typedef struct packed {
		logic              kind;
		logic [POS_W-1:0]  position;
		sum_t              score;
		logic              score_valid;
		logic              best_found;
		logic              hit;
		logic [HITS_W-1:0] hit_count;
		logic              last;
	} res_t;

endpackage

FILE: src/pwm_window_scan_best_match_core.sv
// Position weight matrix scanner. Weights are loaded one per request (tuser 0) into a chain
// of cells, one cell per motif position, each holding its four weights and the partial sum
// of the window that has taken that many bases. A base request (tuser 1) shifts the whole
// chain when it is taken, so bases stream in at one per clock while the output has room;
// the base then waits in the s1 stage register until its results enter the output register.
// The output holds two results; while both are held no new result can enter. After the
// final base of a sequence (tlast) the chain, counter and best-match state clear while no
// request is taken. Weight loads go at one per clock unless a base stalls them. Weights are
// undefined until loaded; motif_width above MAX_WIDTH acts as MAX_WIDTH.
module pwm_window_scan_best_match_core #(
	parameter int MAX_WIDTH   = pwms_pkg::MAX_WIDTH_DEF,
	parameter int MAX_SEQ_LEN = pwms_pkg::MAX_SEQ_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pwms_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [pwms_pkg::SUM_W-1:0]        cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// weight_pos, weight_base, weight_value, base_code, base_valid, zero fill
	input  logic [pwms_pkg::S_DATA_W-1:0]     s_tdata,
	// func
	input  logic                              s_tuser,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// position, score, score_valid, best_found, hit, hit_count, zero fill
	output logic [pwms_pkg::M_DATA_W-1:0]     m_tdata,
	// kind
	output logic                              m_tuser,
	output logic                              m_tlast
);
	import pwms_pkg::*;

	localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WE_W  = $clog2(MAX_WIDTH + 1);
	localparam int CNT_W = $clog2(MAX_SEQ_LEN + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int RES_W = POS_W + SUM_W + 3 + HITS_W;

	logic [MWIDTH_W-1:0] motif_width_q;
	sum_t                threshold_q;

	logic [WPOS_W-1:0]   weight_pos;
	logic [BASE_W-1:0]   weight_base;
	weight_t             weight_value;
	logic [BASE_W-1:0]   base_code;
	logic                base_valid;

	logic                acc;
	logic                load_acc;
	logic                base_acc;
	logic                move;
	logic                clear;
	logic                free;

	logic                s1_q;
	logic                s1_last_q;
	logic [CNT_W-1:0]    cnt_q;

	sum_t                cell_sum [MAX_WIDTH];
	logic                cell_bad [MAX_WIDTH];

	logic [WE_W-1:0]     w_eff;
	logic [IDX_W-1:0]    sel;
	logic [CMP_W-1:0]    start_c;
	eval_t               evt;
	res_t                res;

	assign weight_pos   = s_tdata[WPOS_W-1:0];
	assign weight_base  = s_tdata[WPOS_W+BASE_W-1:WPOS_W];
	assign weight_value = weight_t'(s_tdata[WPOS_W+BASE_W+WEIGHT_W-1:WPOS_W+BASE_W]);
	assign base_code    = s_tdata[WPOS_W+2*BASE_W+WEIGHT_W-1:WPOS_W+BASE_W+WEIGHT_W];
	assign base_valid   = s_tdata[WPOS_W+2*BASE_W+WEIGHT_W];

	// hold off requests while a final base waits to clear the chain or the output has no room
	assign s_tready = !s1_q || (free && !s1_last_q);
	assign acc      = s_tvalid & s_tready;
	assign load_acc = acc && (s_tuser == FUNC_LOAD);
	assign base_acc = acc && (s_tuser == FUNC_BASE);
	assign move     = s1_q & free;
	assign clear    = move & s1_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motif_width_q <= MWIDTH_RST;
			threshold_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MOTIF_WIDTH:   motif_width_q <= cfg_data[MWIDTH_W-1:0];
				REG_HIT_THRESHOLD: threshold_q   <= sum_t'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q      <= 1'b0;
			s1_last_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (base_acc) begin
				s1_q      <= 1'b1;
				s1_last_q <= s_tlast;
			end else if (move) begin
				s1_q <= 1'b0;
			end
			if (clear) begin
				cnt_q <= '0;
			end else if (base_acc && cnt_q < CNT_W'(MAX_SEQ_LEN)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
		sum_t prev_sum;
		logic prev_bad;
		if (k == 0) begin : g_head
			assign prev_sum = '0;
			assign prev_bad = 1'b0;
		end else begin : g_link
			assign prev_sum = cell_sum[k-1];
			assign prev_bad = cell_bad[k-1];
		end
		pwms_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.wr_en      (load_acc && (int'(weight_pos) == k)),
			.wr_base    (weight_base),
			.wr_value   (weight_value),
			.shift_en   (base_acc),
			.clear      (clear),
			.base_code  (base_code),
			.base_valid (base_valid),
			.prev_sum   (prev_sum),
			.prev_bad   (prev_bad),
			.sum        (cell_sum[k]),
			.bad        (cell_bad[k])
		);
	end

	always_comb begin
		if (int'(motif_width_q) > MAX_WIDTH) begin
			w_eff = WE_W'(MAX_WIDTH);
		end else begin
			w_eff = WE_W'(motif_width_q);
		end
		sel     = IDX_W'(w_eff - WE_W'(1));
		start_c = CMP_W'(cnt_q) - CMP_W'(w_eff);

		evt.go       = move;
		evt.last     = s1_last_q;
		evt.win      = (w_eff != '0) && (CMP_W'(cnt_q) >= CMP_W'(w_eff));
		evt.bad      = cell_bad[sel];
		evt.sum      = cell_sum[sel];
		evt.position = (start_c > CMP_W'(POS_MAX)) ? POS_MAX : start_c[POS_W-1:0];
	end

	pwms_score u_score (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.threshold (threshold_q),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.res       (res),
		.free      (free)
	);

	assign m_tuser = res.kind;
	assign m_tlast = res.last;
	assign m_tdata = {{(M_DATA_W-RES_W){1'b0}}, res.hit_count, res.hit, res.best_found,
		res.score_valid, res.score, res.position};

	a_no_take_before_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_q && s1_last_q) |-> !s_tready)
		else $error("request taken while sequence end pending");

	a_counter_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (cnt_q == '0))
		else $error("base counter not cleared after sequence end");

	a_counter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SEQ_LEN))
		else $error("base counter beyond limit");

	a_summary_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_SUMMARY) |-> m_tlast)
		else $error("summary not marked last");

endmodule

FILE: src/pwms_cell.sv
module pwms_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [pwms_pkg::BASE_W-1:0]         wr_base,
	input  pwms_pkg::weight_t                   wr_value,
	input  logic                                shift_en,
	input  logic                                clear,
	input  logic [pwms_pkg::BASE_W-1:0]         base_code,
	input  logic                                base_valid,
	input  pwms_pkg::sum_t                      prev_sum,
	input  logic                                prev_bad,
	output pwms_pkg::sum_t                      sum,
	output logic                                bad
);
	import pwms_pkg::*;

	localparam int EXT_W = SUM_W + 1;

	weight_t            weight_q [4];
	sum_t               sum_q;
	logic               bad_q;
	logic [EXT_W-1:0]   ext;
	sum_t               sat;

	// this position's four weights, one per base
	always_ff @(posedge clk) begin
		if (wr_en) begin
			weight_q[wr_base] <= wr_value;
		end
	end

	always_comb begin
		ext = EXT_W'(prev_sum) + EXT_W'(weight_q[base_code]);
		if (ext[EXT_W-1] != ext[EXT_W-2]) begin
			sat = ext[EXT_W-1] ? SUM_MIN : SUM_MAX;
		end else begin
			sat = sum_t'(ext[SUM_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			bad_q <= 1'b0;
		end else if (clear) begin
			sum_q <= '0;
			bad_q <= 1'b0;
		end else if (shift_en) begin
			// an invalid base poisons the window and passes the previous sum on with no weight added
			bad_q <= prev_bad | ~base_valid;
			sum_q <= base_valid ? sat : prev_sum;
		end
	end

	assign sum = sum_q;
	assign bad = bad_q;

endmodule

FILE: src/pwms_score.sv
module pwms_score (
	input  logic            clk,
	input  logic            arst_n,
	input  pwms_pkg::eval_t evt,
	input  pwms_pkg::sum_t  threshold,
	input  logic            m_tready,
	output logic            m_tvalid,
	output pwms_pkg::res_t  res,
	output logic            free
);
	import pwms_pkg::*;

	logic              best_seen_q;
	sum_t              best_score_q;
	logic [POS_W-1:0]  best_pos_q;
	logic [HITS_W-1:0] hits_q;

	logic              upd;
	logic              seen_n;
	sum_t              score_n;
	logic [POS_W-1:0]  pos_n;
	logic              hit;
	logic [HITS_W-1:0] hits_n;

	res_t res0_q;
	res_t res1_q;
	logic v0_q;
	logic v1_q;
	logic pop;

	assign pop      = m_tvalid & m_tready;
	assign free     = (!v0_q && !v1_q) || (m_tready && !(v0_q && v1_q));
	assign m_tvalid = v0_q | v1_q;
	assign res      = v0_q ? res0_q : res1_q;

	always_comb begin
		// first strictly better valid window wins
		upd     = evt.win && !evt.bad && (!best_seen_q || (evt.sum > best_score_q));
		seen_n  = best_seen_q | upd;
		score_n = upd ? evt.sum : best_score_q;
		pos_n   = upd ? evt.position : best_pos_q;
		hit     = evt.last && seen_n && (score_n >= threshold);
		hits_n  = (hit && hits_q != HITS_MAX) ? hits_q + HITS_W'(1) : hits_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_seen_q  <= 1'b0;
			best_score_q <= '0;
			best_pos_q   <= '0;
			hits_q       <= '0;
			v0_q         <= 1'b0;
			v1_q         <= 1'b0;
		end else begin
			if (evt.go) begin
				// a new request only arrives once no result is held, or a single held one is leaving
				v0_q   <= evt.win;
				v1_q   <= evt.last;
				hits_q <= hits_n;
				if (evt.last) begin
					best_seen_q  <= 1'b0;
					best_score_q <= '0;
					best_pos_q   <= '0;
				end else begin
					best_seen_q  <= seen_n;
					best_score_q <= score_n;
					best_pos_q   <= pos_n;
				end
			end else if (pop) begin
				if (v0_q) begin
					v0_q <= 1'b0;
				end else begin
					v1_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt.go) begin
			res0_q.kind        <= KIND_WINDOW;
			res0_q.position    <= evt.position;
			res0_q.score       <= evt.bad ? '0 : evt.sum;
			res0_q.score_valid <= ~evt.bad;
			res0_q.best_found  <= 1'b0;
			res0_q.hit         <= 1'b0;
			res0_q.hit_count   <= hits_q;
			res0_q.last        <= ~evt.last;

			res1_q.kind        <= KIND_SUMMARY;
			res1_q.position    <= seen_n ? pos_n : '0;
			res1_q.score       <= seen_n ? score_n : '0;
			res1_q.score_valid <= seen_n;
			res1_q.best_found  <= seen_n;
			res1_q.hit         <= hit;
			res1_q.hit_count   <= hits_n;
			res1_q.last        <= 1'b1;
		end
	end

endmodule

FILE: tb/sv/pwm_scan_checker.sv
`timescale 1ns / 1ps

module pwm_scan_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pwms_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [pwms_pkg::SUM_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// weight_pos, weight_base, weight_value, base_code, base_valid, zero fill
	input  logic [pwms_pkg::S_DATA_W-1:0]  s_tdata,
	// func
	input  logic                           s_tuser,
	input  logic                           s_tlast,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// position, score, score_valid, best_found, hit, hit_count, zero fill
	input  logic [pwms_pkg::M_DATA_W-1:0]  m_tdata,
	// kind
	input  logic                           m_tuser,
	input  logic                           m_tlast,
	output int                             mismatches,
	output int                             pending,
	output int                             windows_seen,
	output int                             summaries_seen
);
	import pwms_pkg::*;

	localparam int MAX_W   = MAX_WIDTH_DEF;
	localparam int MAX_SEQ = MAX_SEQ_LEN_DEF;

	logic [MWIDTH_W-1:0] motif_width;
	sum_t                threshold;

	weight_t             weights [4*MAX_W];
	sum_t                cell_sum [MAX_W];
	logic                cell_bad [MAX_W];
	int                  bases_in_seq;
	sum_t                top_score;
	logic [POS_W-1:0]    top_pos;
	logic                top_seen;
	logic [HITS_W-1:0]   hits;

	res_t                scan_results_due [$];

	task automatic clear_sequence();
		for (int k = 0; k < MAX_W; k++) begin
			cell_sum[k] = '0;
			cell_bad[k] = 1'b0;
		end
		bases_in_seq = 0;
		top_score    = '0;
		top_pos      = '0;
		top_seen     = 1'b0;
	endtask

	// shift one base through the cell chain and queue the results it causes
	task automatic score_base(input logic [BASE_W-1:0] code, input logic ok, input logic fin);
		int               w;
		int               acc;
		int               start;
		logic             bad;
		sum_t             sc;
		logic             hit;
		res_t             r;
		w = (int'(motif_width) > MAX_W) ? MAX_W : int'(motif_width);
		for (int k = MAX_W - 1; k > 0; k--) begin
			cell_bad[k] = cell_bad[k-1] || !ok;
			if (ok) begin
				acc = cell_sum[k-1] + weights[k*4 + code];
				if (acc > SUM_MAX)
					cell_sum[k] = SUM_MAX;
				else if (acc < SUM_MIN)
					cell_sum[k] = SUM_MIN;
				else
					cell_sum[k] = acc[SUM_W-1:0];
			end else begin
				cell_sum[k] = cell_sum[k-1];
			end
		end
		cell_bad[0] = !ok;
		cell_sum[0] = ok ? sum_t'(weights[code]) : '0;

		if (bases_in_seq < MAX_SEQ)
			bases_in_seq++;

		if (w > 0 && bases_in_seq >= w) begin
			bad   = cell_bad[w-1];
			sc    = cell_sum[w-1];
			start = bases_in_seq - w;
			if (start > int'(POS_MAX))
				start = int'(POS_MAX);
			// strictly better only: the first of equal windows stays best
			if (!bad && (!top_seen || sc > top_score)) begin
				top_seen  = 1'b1;
				top_score = sc;
				top_pos   = start[POS_W-1:0];
			end
			r.kind        = KIND_WINDOW;
			r.position    = start[POS_W-1:0];
			r.score       = bad ? sum_t'(0) : sc;
			r.score_valid = !bad;
			r.best_found  = 1'b0;
			r.hit         = 1'b0;
			r.hit_count   = hits;
			r.last        = !fin;
			scan_results_due = {scan_results_due, r};
		end

		if (fin) begin
			hit = top_seen && (top_score >= threshold);
			if (hit && hits != HITS_MAX)
				hits++;
			r.kind        = KIND_SUMMARY;
			r.position    = top_seen ? top_pos : '0;
			r.score       = top_seen ? top_score : sum_t'(0);
			r.score_valid = top_seen;
			r.best_found  = top_seen;
			r.hit         = hit;
			r.hit_count   = hits;
			r.last        = 1'b1;
			scan_results_due = {scan_results_due, r};
			clear_sequence();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			motif_width = MWIDTH_RST;
			threshold   = '0;
			hits        = '0;
			for (int k = 0; k < 4*MAX_W; k++)
				weights[k] = '0;
			clear_sequence();
			scan_results_due.delete();
			mismatches     = 0;
			windows_seen   = 0;
			summaries_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.kind        = m_tuser;
				got.position    = m_tdata[15:0];
				got.score       = m_tdata[39:16];
				got.score_valid = m_tdata[40];
				got.best_found  = m_tdata[41];
				got.hit         = m_tdata[42];
				got.hit_count   = m_tdata[58:43];
				got.last        = m_tlast;
				if (got.kind == KIND_SUMMARY)
					summaries_seen++;
				else
					windows_seen++;
				if (scan_results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none due: kind %0d pos %0d score %0d",
							$realtime, got.kind, got.position, got.score);
				end else begin
					want = scan_results_due.pop_front();
					if (got.kind !== want.kind || got.position !== want.position ||
						got.score !== want.score || got.score_valid !== want.score_valid ||
						got.best_found !== want.best_found || got.hit !== want.hit ||
						got.hit_count !== want.hit_count || got.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("%0t: mismatch (exp/got) kind %0d/%0d pos %0d/%0d ",
								$realtime, want.kind, got.kind,
								want.position, got.position);
							$write("score %0d/%0d valid %0d/%0d best %0d/%0d ",
								want.score, got.score, want.score_valid, got.score_valid,
								want.best_found, got.best_found);
							$display("hit %0d/%0d count %0d/%0d last %0d/%0d",
								want.hit, got.hit, want.hit_count, got.hit_count,
								want.last, got.last);
						end
					end
				end
			end

			if (cfg_we) begin
				if (cfg_idx == REG_MOTIF_WIDTH)
					motif_width = cfg_data[MWIDTH_W-1:0];
				else if (cfg_idx == REG_HIT_THRESHOLD)
					threshold = cfg_data;
			end

			if (s_tvalid && s_tready) begin
				if (s_tuser == FUNC_LOAD)
					weights[{s_tdata[4:0], s_tdata[6:5]}] = s_tdata[22:7];
				else
					score_base(s_tdata[24:23], s_tdata[25], s_tlast);
			end
		end
		pending = scan_results_due.size();
	end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import pwms_pkg::*;

	localparam int CYCLE_LIMIT      = 2000000;
	localparam int RANDOM_ITEMS     = 560;
	localparam int SINK_HOLD_CYCLES = 300;
	localparam int TAIL_BASES       = 40;
	localparam int DRAIN_CYCLES     = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [SUM_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;
	logic                 s_tuser;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;

	int mismatches;
	int pending;
	int windows_seen;
	int summaries_seen;
	int requests;
	int cycles;
	int sink_hold;
	bit idle_on;

	pwm_window_scan_best_match_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	pwm_scan_checker scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.mismatches     (mismatches),
		.pending        (pending),
		.windows_seen   (windows_seen),
		.summaries_seen (summaries_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result sink: random stall bursts while idling is on, plus one long hold when asked
	initial begin
		int n;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				n = sink_hold;
				sink_hold = 0;
				m_tready = 1'b0;
				repeat (n - 1) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	function automatic logic [WEIGHT_W-1:0] weight_pick();
		case ($urandom_range(0, 7))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	function automatic int width_pick();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return 32;
			2:       return 63;
			3:       return $urandom_range(33, 62);
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	function automatic logic [SUM_W-1:0] threshold_pick();
		int t;
		case ($urandom_range(0, 7))
			0:       return SUM_MIN;
			1:       return SUM_MAX;
			2:       return '0;
			3:       return SUM_W'($urandom);
			default: begin
				t = $urandom_range(0, 100000);
				return SUM_W'(t - 50000);
			end
		endcase
	endfunction

	// offer one request and hold it until the block takes it
	task automatic offer(input logic fn, input logic [WPOS_W-1:0] wpos,
		input logic [BASE_W-1:0] wbase, input logic [WEIGHT_W-1:0] wval,
		input logic [BASE_W-1:0] code, input logic ok, input logic fin);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = fn;
		s_tlast  = fin;
		s_tdata  = {6'b0, ok, code, wval, wbase, wpos};
		do @(posedge clk); while (!s_tready);
		requests++;
	endtask

	task automatic load_weight(input logic [WPOS_W-1:0] wpos, input logic [BASE_W-1:0] wbase,
		input logic [WEIGHT_W-1:0] wval);
		offer(FUNC_LOAD, wpos, wbase, wval, BASE_W'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic feed_base(input logic [BASE_W-1:0] code, input logic ok, input logic fin);
		offer(FUNC_BASE, WPOS_W'($urandom), BASE_W'($urandom), WEIGHT_W'($urandom),
			code, ok, fin);
	endtask

	// stop offering and let every due result drain
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SUM_W-1:0] data);
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we   = 1'b0;
	endtask

	initial begin
		int i;
		int len;
		int cur_w;
		int phase;
		int phase_items;
		int rand_done;
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_idx  = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every base reads all cells, so fill the whole table first
		for (i = 0; i < 4*MAX_WIDTH_DEF; i++)
			load_weight(WPOS_W'(i / 4), BASE_W'(i % 4), weight_pick());

		// too few bases at the reset width: summary only
		feed_base(2'd0, 1'b1, 1'b0);
		feed_base(2'd1, 1'b1, 1'b0);
		feed_base(2'd2, 1'b1, 1'b1);
		settle();
		write_reg(REG_MOTIF_WIDTH, 24'd2);
		// equal windows: the first must stay best
		load_weight(5'd0, 2'd0, 16'sd256);
		load_weight(5'd1, 2'd0, 16'sd256);
		repeat (3) feed_base(2'd0, 1'b1, 1'b0);
		feed_base(2'd0, 1'b1, 1'b1);
		// invalid symbol in the middle
		feed_base(2'd3, 1'b1, 1'b0);
		feed_base(2'd1, 1'b0, 1'b0);
		feed_base(2'd2, 1'b1, 1'b0);
		feed_base(2'd1, 1'b1, 1'b1);
		// no valid window at all
		feed_base(2'd2, 1'b0, 1'b0);
		feed_base(2'd3, 1'b0, 1'b1);
		settle();
		write_reg(REG_HIT_THRESHOLD, SUM_MAX);
		feed_base(2'd3, 1'b1, 1'b0);
		feed_base(2'd0, 1'b1, 1'b0);
		feed_base(2'd1, 1'b1, 1'b1);
		settle();
		write_reg(REG_HIT_THRESHOLD, SUM_MIN);
		feed_base(2'd3, 1'b1, 1'b0);
		feed_base(2'd0, 1'b1, 1'b0);
		feed_base(2'd1, 1'b1, 1'b1);
		settle();
		write_reg(REG_MOTIF_WIDTH, 24'd0);
		feed_base(2'd2, 1'b1, 1'b0);
		feed_base(2'd1, 1'b1, 1'b1);
		settle();
		write_reg(REG_MOTIF_WIDTH, 24'd1);
		feed_base(2'd0, 1'b1, 1'b0);
		feed_base(2'd3, 1'b1, 1'b0);
		// widen part way through the sequence
		settle();
		write_reg(REG_MOTIF_WIDTH, 24'd3);
		feed_base(2'd2, 1'b1, 1'b0);
		feed_base(2'd1, 1'b1, 1'b1);

		rand_done = 0;
		phase = 0;
		while (rand_done < RANDOM_ITEMS) begin
			settle();
			// phase 1 keeps the sender busy against the long sink hold
			idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
			cur_w = width_pick();
			write_reg(REG_MOTIF_WIDTH, SUM_W'(cur_w));
			write_reg(REG_HIT_THRESHOLD, threshold_pick());
			if (phase == 1)
				sink_hold = SINK_HOLD_CYCLES;
			phase_items = 0;
			while (phase_items < 60) begin
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 6)) begin
						load_weight(WPOS_W'($urandom_range(0, 31)),
							BASE_W'($urandom_range(0, 3)), weight_pick());
						phase_items++;
					end
				end
				len = $urandom_range(1, (cur_w > 32 ? 32 : cur_w) * 2 + 4);
				for (i = 0; i < len; i++) begin
					if (i > 0 && $urandom_range(0, 40) == 0) begin
						settle();
						cur_w = width_pick();
						write_reg(REG_MOTIF_WIDTH, SUM_W'(cur_w));
					end
					feed_base(BASE_W'($urandom_range(0, 3)), $urandom_range(0, 9) != 0,
						i == len - 1);
					phase_items++;
				end
			end
			rand_done += phase_items;
			phase++;
		end

		// closing stretch at full rate with no idling on either side
		settle();
		idle_on = 1'b0;
		write_reg(REG_MOTIF_WIDTH, 24'd1);
		write_reg(REG_HIT_THRESHOLD, SUM_MIN);
		for (i = 0; i < TAIL_BASES; i++)
			feed_base(BASE_W'($urandom_range(0, 3)), $urandom_range(0, 19) != 0,
				i == TAIL_BASES - 1);
		// one-base sequences back to back, each a hit
		for (i = 0; i < TAIL_BASES; i++)
			feed_base(BASE_W'($urandom_range(0, 3)), 1'b1, 1'b1);

		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d requests in %0d random phases plus directed and full-rate runs",
			requests, phase);
		$display("checked %0d window results and %0d summaries, %0d mismatches, %0d still due",
			windows_seen, summaries_seen, mismatches, pending);
		if (mismatches == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
